// ===== rtl/colstd_pkg.sv =====
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// colstd_pkg
// Shared constants and types of the column standardizer.
// ----------------------------------------------------------------------------
package colstd_pkg;

    localparam int MAX_ROWS    = 1024;
    localparam int MAX_COLUMNS = 16;
    localparam int SAMPLE_BITS = 16;

    localparam int COL_BITS  = $clog2(MAX_COLUMNS);
    localparam int ROW_BITS  = $clog2(MAX_ROWS);
    localparam int CNT_BITS  = ROW_BITS + 1;
    localparam int ADDR_BITS = ROW_BITS + COL_BITS;
    localparam int SUM_BITS  = 26;
    localparam int SQ_BITS   = 42;
    localparam int DIV_BITS  = 64;

    localparam logic [1:0] STATUS_OK       = 2'd0;
    localparam logic [1:0] STATUS_NOT_READY = 2'd1;
    localparam logic [1:0] STATUS_RANGE    = 2'd2;

    localparam logic CMD_LOAD = 1'b0;
    localparam logic CMD_READ = 1'b1;

    typedef enum logic [3:0] {
        ST_IDLE,
        ST_CLEAR,
        ST_F_MUL,
        ST_F_VAR,
        ST_F_SQRT,
        ST_F_MEAN,
        ST_F_STORE,
        ST_R_FETCH,
        ST_R_DIV,
        ST_R_OUT
    } state_t;

    typedef struct packed {
        logic                start;
        logic [DIV_BITS-1:0] num;
        logic [DIV_BITS-1:0] den;
    } div_req_t;

    typedef struct packed {
        logic                done;
        logic [DIV_BITS-1:0] quo;
        logic [DIV_BITS-1:0] rem;
    } div_rsp_t;

endpackage
`default_nettype wire

// ===== rtl/column_standardizer.sv =====
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// column_standardizer
// Z-score standardization of a table of Q8.8 samples, column by column.
// ----------------------------------------------------------------------------
//  channel   signals                                         direction
//  command   start, busy, command, sample_value,             in (busy out)
//            last_of_data, row_index, column_index
//  result    result_valid, norm_value, column_mean,          out
//            column_deviation, saturated, status
//  config    cfg_valid, cfg_ready, cfg_data                  in (ready out)
//
//  A load passes through ST_CLEAR. A load marked last then runs the statistics
//  pass: per column the products n*sumsq, sum^2 and n*n, a 64-step variance
//  divide, a 32-step square root and a 64-step mean divide. Both divides and
//  the one divide of a read all run on the one shared divider unit.
//  Reset is asynchronous; the sample memory is not cleared. Results are
//  strobed for one cycle and cannot be stalled.
// ----------------------------------------------------------------------------
module column_standardizer (
    input  wire logic        clk,
    input  wire logic        rst_n,
    input  wire logic        start,
    output logic             busy,
    input  wire logic        command,
    input  wire logic [15:0] sample_value,
    input  wire logic        last_of_data,
    input  wire logic [9:0]  row_index,
    input  wire logic [3:0]  column_index,
    output logic             result_valid,
    output logic [15:0]      norm_value,
    output logic [15:0]      column_mean,
    output logic [15:0]      column_deviation,
    output logic             saturated,
    output logic [1:0]       status,
    input  wire logic        cfg_valid,
    output logic             cfg_ready,
    input  wire logic [4:0]  cfg_data
);
    import colstd_pkg::*;

    // sample memory
    logic signed [SAMPLE_BITS-1:0] mem [MAX_ROWS*MAX_COLUMNS];
    logic                          mem_we;
    logic [ADDR_BITS-1:0]          mem_waddr, mem_raddr;
    logic signed [SAMPLE_BITS-1:0] mem_wdata, mem_rdata;

    always_ff @(posedge clk)
    begin
        if (mem_we)
            mem[mem_waddr] <= mem_wdata;
        mem_rdata <= mem[mem_raddr];
    end

    logic signed [SUM_BITS-1:0] sum_reg  [MAX_COLUMNS];
    logic [SQ_BITS-1:0]         sq_reg   [MAX_COLUMNS];
    logic signed [15:0]         mean_reg [MAX_COLUMNS];
    logic [15:0]                dev_reg  [MAX_COLUMNS];

    state_t               state_reg, state_next;
    logic [4:0]           ncol_reg;
    logic [CNT_BITS-1:0]  rows_reg, rows_next;
    logic [COL_BITS-1:0]  pos_reg, pos_next;
    logic                 ready_reg, ready_next;
    logic [COL_BITS-1:0]  col_reg, col_next;
    logic                 lastc_reg, lastc_next;
    logic [DIV_BITS-1:0]  acc_reg, acc_next;
    logic [DIV_BITS-1:0]  tmp_reg, tmp_next;
    logic [5:0]           cnt_reg, cnt_next;
    logic                 neg_reg, neg_next;
    logic [15:0]          dev_hold_reg, dev_hold_next;
    logic signed [15:0]   mean_hold_reg, mean_hold_next;

    logic                 clr_sums, acc_en, store_en;
    logic signed [SAMPLE_BITS-1:0] ld_sample_reg;

    logic                 rv_next;
    logic [15:0]          nv_next, cm_next, cd_next;
    logic                 sat_next;
    logic [1:0]           st_next;

    div_req_t dreq;
    div_rsp_t drsp;

    colstd_divider u_div (
        .clk   (clk),
        .rst_n (rst_n),
        .req   (dreq),
        .rsp   (drsp)
    );

    logic [4:0]          act_cols;
    assign act_cols = (ncol_reg == 5'd0) ? 5'd1 :
                      (ncol_reg > 5'(MAX_COLUMNS)) ? 5'(MAX_COLUMNS) : ncol_reg;

    logic [CNT_BITS-1:0] n_col;
    assign n_col = rows_reg + CNT_BITS'(col_reg < pos_reg);

    logic [CNT_BITS-1:0] n_rd;
    assign n_rd = rows_reg + CNT_BITS'(column_index < pos_reg);

    logic [SUM_BITS-1:0] smag;
    assign smag = sum_reg[col_reg][SUM_BITS-1] ? SUM_BITS'(-sum_reg[col_reg])
                                                 : sum_reg[col_reg];

    // square root step: one result bit per cycle
    logic [DIV_BITS-1:0] sq_bit, sq_trial;
    assign sq_bit   = DIV_BITS'(1) << {cnt_reg[4:0], 1'b0};
    assign sq_trial = tmp_reg + sq_bit;

    logic signed [17:0] diff;
    assign diff = 18'(ld_sample_reg) - 18'(mean_hold_reg);

    assign busy      = (state_reg != ST_IDLE);
    assign cfg_ready = 1'b1;

    always_comb
    begin
        state_next    = state_reg;
        rows_next     = rows_reg;
        pos_next      = pos_reg;
        ready_next    = ready_reg;
        col_next      = col_reg;
        lastc_next    = lastc_reg;
        acc_next      = acc_reg;
        tmp_next      = tmp_reg;
        cnt_next      = cnt_reg;
        neg_next      = neg_reg;
        dev_hold_next = dev_hold_reg;
        mean_hold_next = mean_hold_reg;
        clr_sums      = 1'b0;
        acc_en        = 1'b0;
        store_en      = 1'b0;
        mem_we        = 1'b0;
        mem_waddr     = {rows_reg[ROW_BITS-1:0], pos_reg};
        mem_wdata     = ld_sample_reg;
        mem_raddr     = {row_index, column_index};
        dreq.start    = 1'b0;
        dreq.num      = acc_reg;
        dreq.den      = tmp_reg;
        rv_next       = 1'b0;
        nv_next       = '0;
        cm_next       = '0;
        cd_next       = 16'd1;
        sat_next      = 1'b0;
        st_next       = STATUS_OK;
        case (state_reg)
            ST_IDLE:
            begin
                if (start && command == CMD_LOAD)
                begin
                    lastc_next = last_of_data;
                    if (ready_reg)
                    begin
                        // new data set: clear sums first
                        clr_sums   = 1'b1;
                        rows_next  = '0;
                        pos_next   = '0;
                        ready_next = 1'b0;
                        state_next = ST_CLEAR;
                    end
                    else
                        state_next = ST_CLEAR;
                end
                else if (start)
                begin
                    if (!ready_reg)
                    begin
                        rv_next = 1'b1;
                        st_next = STATUS_NOT_READY;
                    end
                    else if (5'(column_index) >= act_cols || {1'b0, row_index} >= n_rd)
                    begin
                        rv_next = 1'b1;
                        st_next = STATUS_RANGE;
                    end
                    else
                    begin
                        col_next   = column_index;
                        state_next = ST_R_FETCH;
                    end
                end
            end
            ST_CLEAR:
            begin
                // take the load sample
                if (rows_reg < CNT_BITS'(MAX_ROWS))
                begin
                    mem_we = 1'b1;
                    acc_en = 1'b1;
                    if (5'(pos_reg) + 5'd1 >= act_cols)
                    begin
                        pos_next  = '0;
                        rows_next = rows_reg + 1'b1;
                    end
                    else
                        pos_next = pos_reg + 1'b1;
                end
                if (lastc_reg)
                begin
                    col_next   = '0;
                    state_next = ST_F_MUL;
                end
                else
                    state_next = ST_IDLE;
            end
            ST_F_MUL:
            begin
                if (n_col == '0)
                begin
                    dev_hold_next  = 16'd1;
                    mean_hold_next = '0;
                    state_next     = ST_F_STORE;
                end
                else
                begin
                    // acc = n*sumsq, tmp = sum^2; ST_F_VAR then clamps acc - tmp and sets tmp = n*n
                    acc_next = DIV_BITS'(n_col) * DIV_BITS'(sq_reg[col_reg]);
                    tmp_next = DIV_BITS'(smag) * DIV_BITS'(smag);
                    state_next = ST_F_VAR;
                    cnt_next   = '0;
                end
            end
            ST_F_VAR:
            begin
                if (cnt_reg == 6'd0)
                begin
                    acc_next   = (acc_reg > tmp_reg) ? acc_reg - tmp_reg : '0;
                    tmp_next   = DIV_BITS'(n_col) * DIV_BITS'(n_col);
                    cnt_next   = 6'd1;
                end
                else if (cnt_reg == 6'd1)
                begin
                    dreq.start = 1'b1;
                    cnt_next   = 6'd2;
                end
                else if (drsp.done)
                begin
                    acc_next   = drsp.quo;
                    tmp_next   = '0;
                    cnt_next   = 6'd31;
                    state_next = ST_F_SQRT;
                end
            end
            ST_F_SQRT:
            begin
                // tmp holds root shifted, acc the remainder
                if (acc_reg >= sq_trial)
                begin
                    acc_next = acc_reg - sq_trial;
                    tmp_next = (tmp_reg >> 1) + sq_bit;
                end
                else
                    tmp_next = tmp_reg >> 1;
                cnt_next = cnt_reg - 1'b1;
                if (cnt_reg == 6'd0)
                begin
                    dev_hold_next = (tmp_next == '0) ? 16'd1 : tmp_next[15:0];
                    neg_next   = sum_reg[col_reg][SUM_BITS-1];
                    acc_next   = DIV_BITS'({smag, 1'b0}) + DIV_BITS'(n_col);
                    tmp_next   = DIV_BITS'({n_col, 1'b0});
                    dreq.start = 1'b0;
                    cnt_next   = 6'd1;
                    state_next = ST_F_MEAN;
                end
            end
            ST_F_MEAN:
            begin
                if (cnt_reg == 6'd1)
                begin
                    dreq.start = 1'b1;
                    cnt_next   = 6'd0;
                end
                else if (drsp.done)
                begin
                    mean_hold_next = neg_reg ? 16'(-drsp.quo[15:0]) : drsp.quo[15:0];
                    state_next     = ST_F_STORE;
                end
            end
            ST_F_STORE:
            begin
                store_en = 1'b1;
                if (col_reg == COL_BITS'(MAX_COLUMNS - 1))
                begin
                    ready_next = 1'b1;
                    state_next = ST_IDLE;
                end
                else
                begin
                    col_next   = col_reg + 1'b1;
                    state_next = ST_F_MUL;
                end
            end
            ST_R_FETCH:
            begin
                // memory data lands in ld_sample_reg next
                mean_hold_next = mean_reg[col_reg];
                dev_hold_next  = dev_reg[col_reg];
                cnt_next       = 6'd2;
                state_next     = ST_R_DIV;
            end
            ST_R_DIV:
            begin
                if (cnt_reg == 6'd2)
                begin
                    neg_next = diff[17];
                    acc_next = DIV_BITS'({(diff[17] ? 18'(-diff) : diff), 9'd0})
                               + DIV_BITS'(dev_hold_reg);
                    tmp_next = DIV_BITS'({dev_hold_reg, 1'b0});
                    cnt_next = 6'd1;
                end
                else if (cnt_reg == 6'd1)
                begin
                    dreq.start = 1'b1;
                    cnt_next   = 6'd0;
                end
                else if (drsp.done)
                begin
                    acc_next   = drsp.quo;
                    state_next = ST_R_OUT;
                end
            end
            ST_R_OUT:
            begin
                rv_next = 1'b1;
                cm_next = mean_hold_reg;
                cd_next = dev_hold_reg;
                if (!neg_reg)
                begin
                    if (acc_reg > DIV_BITS'(32767))
                    begin
                        nv_next  = 16'h7FFF;
                        sat_next = 1'b1;
                    end
                    else
                        nv_next = acc_reg[15:0];
                end
                else
                begin
                    if (acc_reg > DIV_BITS'(32768))
                    begin
                        nv_next  = 16'h8000;
                        sat_next = 1'b1;
                    end
                    else
                        nv_next = 16'(-acc_reg[15:0]);
                end
                state_next = ST_IDLE;
            end
            default:
                state_next = ST_IDLE;
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= ST_IDLE;
            ncol_reg  <= 5'd1;
            rows_reg  <= '0;
            pos_reg   <= '0;
            ready_reg <= 1'b0;
            result_valid <= 1'b0;
            for (int i = 0; i < MAX_COLUMNS; i++)
            begin
                sum_reg[i]  <= '0;
                sq_reg[i]   <= '0;
                mean_reg[i] <= '0;
                dev_reg[i]  <= 16'd1;
            end
        end
        else
        begin
            state_reg <= state_next;
            rows_reg  <= rows_next;
            pos_reg   <= pos_next;
            ready_reg <= ready_next;
            result_valid <= rv_next;
            if (cfg_valid && cfg_ready)
                ncol_reg <= cfg_data;
            for (int i = 0; i < MAX_COLUMNS; i++)
            begin
                if (clr_sums)
                begin
                    sum_reg[i] <= '0;
                    sq_reg[i]  <= '0;
                end
            end
            if (acc_en)
            begin
                sum_reg[pos_reg] <= sum_reg[pos_reg] + SUM_BITS'(ld_sample_reg);
                sq_reg[pos_reg]  <= sq_reg[pos_reg]
                                    + SQ_BITS'(32'(ld_sample_reg) * 32'(ld_sample_reg));
            end
            if (store_en)
            begin
                mean_reg[col_reg] <= mean_hold_reg;
                dev_reg[col_reg]  <= dev_hold_reg;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        col_reg       <= col_next;
        lastc_reg     <= lastc_next;
        acc_reg       <= acc_next;
        tmp_reg       <= tmp_next;
        cnt_reg       <= cnt_next;
        neg_reg       <= neg_next;
        dev_hold_reg  <= dev_hold_next;
        mean_hold_reg <= mean_hold_next;
        norm_value       <= nv_next;
        column_mean      <= cm_next;
        column_deviation <= cd_next;
        saturated        <= sat_next;
        status           <= st_next;
        // capture the load sample, or the memory word for a read
        if (state_reg == ST_IDLE)
            ld_sample_reg <= sample_value;
        else if (state_reg == ST_R_FETCH)
            ld_sample_reg <= mem_rdata;
    end

    // ------------------------------------------------------------------
    a_one_result: assert property (@(posedge clk) disable iff (!rst_n)
        result_valid |=> !result_valid || $past(start))
        else $error("back to back results without a command");
    a_ready_idle: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == ST_F_STORE && col_reg == COL_BITS'(MAX_COLUMNS - 1)) |=> ready_reg)
        else $error("statistics pass ended without ready");
    a_dev_floor: assert property (@(posedge clk) disable iff (!rst_n)
        result_valid |-> column_deviation != 16'd0)
        else $error("zero deviation reported");

endmodule
`default_nettype wire

// ===== rtl/colstd_divider.sv =====
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// colstd_divider
// Unsigned restoring divider, one quotient bit per cycle.
// ----------------------------------------------------------------------------
module colstd_divider (
    input  wire logic                  clk,
    input  wire logic                  rst_n,
    input  wire colstd_pkg::div_req_t  req,
    output colstd_pkg::div_rsp_t       rsp
);
    import colstd_pkg::*;

    localparam int STEP_BITS = $clog2(DIV_BITS + 1);

    logic [DIV_BITS-1:0]  quo_reg, quo_next;
    logic [DIV_BITS-1:0]  rem_reg, rem_next;
    logic [DIV_BITS-1:0]  den_reg, den_next;
    logic [STEP_BITS-1:0] step_reg, step_next;
    logic                 busy_reg, busy_next;
    logic                 done_reg, done_next;
    logic [DIV_BITS:0]    trial;

    always_comb
    begin
        quo_next  = quo_reg;
        rem_next  = rem_reg;
        den_next  = den_reg;
        step_next = step_reg;
        busy_next = busy_reg;
        done_next = 1'b0;
        trial     = {rem_reg, quo_reg[DIV_BITS-1]};
        if (req.start)
        begin
            quo_next  = req.num;
            rem_next  = '0;
            den_next  = req.den;
            step_next = STEP_BITS'(DIV_BITS);
            busy_next = 1'b1;
        end
        else if (busy_reg)
        begin
            // shift in one numerator bit, subtract when it fits
            if (trial >= {1'b0, den_reg})
            begin
                rem_next = DIV_BITS'(trial - {1'b0, den_reg});
                quo_next = {quo_reg[DIV_BITS-2:0], 1'b1};
            end
            else
            begin
                rem_next = trial[DIV_BITS-1:0];
                quo_next = {quo_reg[DIV_BITS-2:0], 1'b0};
            end
            step_next = step_reg - 1'b1;
            if (step_reg == STEP_BITS'(1))
            begin
                busy_next = 1'b0;
                done_next = 1'b1;
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            busy_reg <= 1'b0;
            done_reg <= 1'b0;
            step_reg <= '0;
        end
        else
        begin
            busy_reg <= busy_next;
            done_reg <= done_next;
            step_reg <= step_next;
        end
    end

    always_ff @(posedge clk)
    begin
        quo_reg <= quo_next;
        rem_reg <= rem_next;
        den_reg <= den_next;
    end

    assign rsp.done = done_reg;
    assign rsp.quo  = quo_reg;
    assign rsp.rem  = rem_reg;

endmodule
`default_nettype wire

// ===== tb/column_standardizer_checker.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// column_standardizer_checker
// Watches the command, result and config channels of the column
// standardizer, keeps its own copy of the table and column statistics,
// predicts every read result and compares it field by field.
// ----------------------------------------------------------------------------
module column_standardizer_checker (
    input  wire logic        clk,
    input  wire logic        rst_n,
    input  wire logic        start,
    input  wire logic        busy,
    input  wire logic        command,
    input  wire logic [15:0] sample_value,
    input  wire logic        last_of_data,
    input  wire logic [9:0]  row_index,
    input  wire logic [3:0]  column_index,
    input  wire logic        result_valid,
    input  wire logic [15:0] norm_value,
    input  wire logic [15:0] column_mean,
    input  wire logic [15:0] column_deviation,
    input  wire logic        saturated,
    input  wire logic [1:0]  status,
    input  wire logic        cfg_valid,
    input  wire logic        cfg_ready,
    input  wire logic [4:0]  cfg_data,
    output int               fail_count,
    output int               pending
);
    import colstd_pkg::*;

    typedef struct packed {
        logic [15:0] norm;
        logic [15:0] mean;
        logic [15:0] dev;
        logic        sat;
        logic [1:0]  stat;
    } std_result_t;

    std_result_t       expected_q[$];
    logic signed [15:0] table_mem [0:MAX_ROWS*MAX_COLUMNS-1];
    longint            col_sum [MAX_COLUMNS];
    longint unsigned   col_sq [MAX_COLUMNS];
    longint            col_mean [MAX_COLUMNS];
    longint unsigned   col_dev [MAX_COLUMNS];
    int unsigned       rows_done;
    int unsigned       col_pos;
    bit                stats_valid;
    logic [4:0]        ncols_reg;

    assign pending = expected_q.size();

    function automatic int unsigned active_cols();
        if (ncols_reg == 0) return 1;
        if (ncols_reg > MAX_COLUMNS) return MAX_COLUMNS;
        return ncols_reg;
    endfunction

    function automatic int unsigned samples_in(int unsigned c);
        return rows_done + ((c < col_pos) ? 1 : 0);
    endfunction

    // nearest, ties away from zero
    function automatic longint div_round(longint num, longint unsigned den);
        longint unsigned mag;
        longint unsigned q;
        mag = (num < 0) ? longint'(-num) : longint'(num);
        q = (mag * 2 + den) / (den * 2);
        return (num < 0) ? -longint'(q) : longint'(q);
    endfunction

    function automatic longint unsigned int_sqrt(longint unsigned v);
        longint unsigned r;
        longint unsigned b;
        r = 0;
        b = 64'h4000_0000_0000_0000;
        while (b > v) b >>= 2;
        while (b != 0) begin
            if (v >= r + b) begin
                v -= r + b;
                r = (r >> 1) + b;
            end
            else r >>= 1;
            b >>= 2;
        end
        return r;
    endfunction

    task automatic clear_set();
        for (int c = 0; c < MAX_COLUMNS; c++) begin
            col_sum[c] = 0;
            col_sq[c] = 0;
        end
        rows_done = 0;
        col_pos = 0;
        stats_valid = 0;
    endtask

    task automatic close_set();
        longint unsigned n, smag, a, b, var_q, sd;
        for (int c = 0; c < MAX_COLUMNS; c++) begin
            n = samples_in(c);
            if (n == 0) begin
                col_mean[c] = 0;
                col_dev[c] = 1;
            end
            else begin
                smag = (col_sum[c] < 0) ? longint'(-col_sum[c]) : longint'(col_sum[c]);
                a = n * col_sq[c];
                b = smag * smag;
                var_q = (a > b) ? (a - b) / (n * n) : 0;
                sd = int_sqrt(var_q);
                col_mean[c] = div_round(col_sum[c], n);
                col_dev[c] = (sd < 1) ? 1 : sd;
            end
        end
        stats_valid = 1;
    endtask

    task automatic take_load(logic signed [15:0] x, logic last);
        longint xv;
        xv = x;
        if (stats_valid) clear_set();
        if (rows_done < MAX_ROWS) begin
            table_mem[rows_done * MAX_COLUMNS + col_pos] = x;
            col_sum[col_pos] += xv;
            col_sq[col_pos] += longint'(xv * xv);
            if (col_pos + 1 >= active_cols()) begin
                col_pos = 0;
                rows_done++;
            end
            else col_pos++;
        end
        if (last) close_set();
    endtask

    function automatic std_result_t predict_read(int unsigned row, int unsigned col);
        std_result_t r;
        longint x, m, v;
        r = '{norm: 16'd0, mean: 16'd0, dev: 16'd1, sat: 1'b0, stat: STATUS_NOT_READY};
        if (!stats_valid) return r;
        if (col >= active_cols() || row >= samples_in(col)) begin
            r.stat = STATUS_RANGE;
            return r;
        end
        x = table_mem[row * MAX_COLUMNS + col];
        m = col_mean[col];
        v = div_round((x - m) * 256, col_dev[col]);
        if (v > 32767) begin
            v = 32767;
            r.sat = 1;
        end
        if (v < -32768) begin
            v = -32768;
            r.sat = 1;
        end
        r.norm = v[15:0];
        r.mean = m[15:0];
        r.dev = col_dev[col][15:0];
        r.stat = STATUS_OK;
        return r;
    endfunction

    task automatic report(string field, logic [15:0] got, logic [15:0] want);
        $display("[%0t] MISMATCH %s: got %0h, expected %0h", $realtime, field, got, want);
        fail_count++;
    endtask

    always @(posedge clk or negedge rst_n)
    begin
        std_result_t e;
        if (!rst_n) begin
            clear_set();
            for (int c = 0; c < MAX_COLUMNS; c++) begin
                col_mean[c] = 0;
                col_dev[c] = 1;
            end
            ncols_reg = 5'd1;
            fail_count = 0;
            expected_q.delete();
        end
        else begin
            if (result_valid) begin
                if (expected_q.size() == 0) report("unexpected result", status, 0);
                else begin
                    e = expected_q.pop_front();
                    if (status !== e.stat) report("status", status, e.stat);
                    if (norm_value !== e.norm) report("norm_value", norm_value, e.norm);
                    if (column_mean !== e.mean) report("column_mean", column_mean, e.mean);
                    if (column_deviation !== e.dev)
                        report("column_deviation", column_deviation, e.dev);
                    if (saturated !== e.sat) report("saturated", saturated, e.sat);
                end
            end
            if (cfg_valid && cfg_ready) ncols_reg = cfg_data;
            if (start && !busy) begin
                if (command == CMD_LOAD) take_load(sample_value, last_of_data);
                else expected_q.push_back(predict_read(row_index, column_index));
            end
        end
    end

endmodule

// ===== tb/column_standardizer_test.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// column_standardizer_test
// Drives load and read items and config writes into the column
// standardizer: a directed opening, then random data sets.
// ----------------------------------------------------------------------------
module column_standardizer_test;
    import colstd_pkg::*;

    localparam longint CYCLE_LIMIT = 3_000_000;

    logic        clk;
    logic        rst_n;
    logic        start;
    logic        busy;
    logic        command;
    logic [15:0] sample_value;
    logic        last_of_data;
    logic [9:0]  row_index;
    logic [3:0]  column_index;
    logic        result_valid;
    logic [15:0] norm_value;
    logic [15:0] column_mean;
    logic [15:0] column_deviation;
    logic        saturated;
    logic [1:0]  status;
    logic        cfg_valid;
    logic        cfg_ready;
    logic [4:0]  cfg_data;
    int          fail_count;
    int          pending;

    int          idle_pct;
    int          load_count;
    int          read_count;
    int          set_count;
    int          set_loads;
    int          set_cols;
    longint      cycles = 0;

    column_standardizer DUT (.*);

    column_standardizer_checker checker_i (.*);

    initial
    begin
        clk = 1'b0;
        forever #4 clk = ~clk;
    end

    always @(posedge clk)
    begin
        cycles <= cycles + 1;
        if (cycles > CYCLE_LIMIT) begin
            $display("Timeout after %0d cycles", cycles);
            $display("Verification failed");
            $finish;
        end
    end

    task automatic send(logic cmd, logic [15:0] x, logic last, logic [9:0] row,
                        logic [3:0] col);
        int gap;
        gap = 0;
        if ($urandom_range(99) < idle_pct) gap = $urandom_range(6, 1);
        if (gap > 0) begin
            start <= 1'b0;
            repeat (gap) @(posedge clk);
        end
        start <= 1'b1;
        command <= cmd;
        sample_value <= x;
        last_of_data <= last;
        row_index <= row;
        column_index <= col;
        do @(posedge clk); while (busy);
        if (cmd == CMD_LOAD) begin
            load_count++;
            set_loads++;
        end
        else read_count++;
    endtask

    task automatic load(logic [15:0] x, logic last);
        send(CMD_LOAD, x, last, 10'($urandom), 4'($urandom));
    endtask

    task automatic read(logic [9:0] row, logic [3:0] col);
        send(CMD_READ, 16'($urandom), 1'($urandom), row, col);
    endtask

    // let the statistics pass finish before touching the register
    task automatic settle();
        start <= 1'b0;
        repeat (4) @(posedge clk);
        do @(posedge clk); while (pending != 0 || busy);
        repeat (40) @(posedge clk);
    endtask

    task automatic write_cols(logic [4:0] v);
        settle();
        cfg_valid <= 1'b1;
        cfg_data <= v;
        do @(posedge clk); while (!cfg_ready);
        cfg_valid <= 1'b0;
        set_cols = (v == 0) ? 1 : (v > MAX_COLUMNS) ? MAX_COLUMNS : v;
        set_loads = 0;
    endtask

    // row and column of a stored entry in the current set
    task automatic read_valid();
        int c;
        int n;
        c = $urandom_range(set_cols - 1);
        n = set_loads / set_cols + ((c < set_loads % set_cols) ? 1 : 0);
        if (n == 0) c = 0;
        n = set_loads / set_cols + ((c < set_loads % set_cols) ? 1 : 0);
        read(10'($urandom_range(n - 1)), 4'(c));
    endtask

    function automatic logic [15:0] pick_sample(int mode);
        case (mode)
            0: return 16'($urandom);
            1: return 16'($signed($urandom_range(8)) - 4);
            2: return $urandom_range(1) ? 16'h8000 : 16'h7FFF;
            default: return 16'($signed($urandom_range(600)) - 300);
        endcase
    endfunction

    task automatic random_set();
        int nrows;
        int nloads;
        int mode;
        int nreads;
        int pick;
        logic [4:0] cols_list [10] = '{1, 2, 3, 4, 7, 8, 15, 16, 0, 31};
        pick = $urandom_range(10);
        write_cols(pick == 10 ? 5'($urandom) : cols_list[pick]);
        nrows = (set_cols > 8) ? $urandom_range(3, 1) : $urandom_range(8, 1);
        nloads = nrows * set_cols + (($urandom_range(3) == 0) ? $urandom_range(set_cols - 1) : 0);
        mode = $urandom_range(3);
        if ($urandom_range(4) == 0) read(10'($urandom), 4'($urandom));
        for (int i = 0; i < nloads; i++) load(pick_sample(mode), i == nloads - 1);
        set_count++;
        nreads = $urandom_range(14, 4);
        for (int i = 0; i < nreads; i++) begin
            if ($urandom_range(4) == 0) read(10'($urandom), 4'($urandom));
            else read_valid();
        end
    endtask

    initial
    begin
        rst_n = 1'b0;
        start = 1'b0;
        command = CMD_LOAD;
        sample_value = '0;
        last_of_data = 1'b0;
        row_index = '0;
        column_index = '0;
        cfg_valid = 1'b0;
        cfg_data = 5'd1;
        idle_pct = 22;
        load_count = 0;
        read_count = 0;
        set_count = 0;
        set_loads = 0;
        set_cols = 1;
        repeat (12) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // nothing loaded yet: statistics not ready
        read(0, 0);
        write_cols(5'd3);
        load(16'h8000, 1'b0);
        load(16'h7FFF, 1'b0);
        load(16'h0000, 1'b0);
        load(16'h0100, 1'b0);
        load(16'hFFFF, 1'b0);
        read(0, 0);
        load(16'h0001, 1'b0);
        load(16'h0064, 1'b1);
        set_count++;
        read(0, 0);
        read(1, 1);
        read(2, 0);
        read(2, 1);
        read(0, 3);
        read(0, 15);
        read(1023, 0);
        send(CMD_READ, 16'hFFFF, 1'b1, 10'd1, 4'd2);
        read(0, 2);

        for (int phase = 0; phase < 3; phase++) begin
            idle_pct = (phase == 0) ? 22 : (phase == 1) ? 65 : 0;
            while (load_count + read_count < 250 * (phase + 1)) random_set();
        end

        settle();
        $display("Covered %0d loads, %0d reads, %0d data sets, column counts 0..31.",
                 load_count, read_count, set_count);
        if (fail_count == 0) $display("Verification passed");
        else $display("Verification failed");
        $finish;
    end

endmodule
